FILE: hdl/elfd_pkg.sv
// Shared types and constants for the escaped length-prefixed frame deframer.
// Holds result kinds, register indexes and the structs passed between modules.
// No dependencies.
package elfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int TAKEN_W   = 17;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] OFFSET_RST = 8'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escape_offset;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  index;
    logic              last;
    logic [LEN_W-1:0]  frame_length;
    logic [CNT_W-1:0]  error_count;
  } result_t;

endpackage

FILE: hdl/elfd_cfg.sv
// Configuration register file: start byte, escape byte and escape offset.
// Depends on elfd_pkg.
module elfd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [elfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [elfd_pkg::BYTE_W-1:0]      cfg_data,
  output elfd_pkg::cfg_t                   cfg_o
);
  import elfd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_START:  cfg_nxt.start_byte    = cfg_data;
        CFG_ESCAPE: cfg_nxt.escape_byte   = cfg_data;
        CFG_OFFSET: cfg_nxt.escape_offset = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= START_RST;
      cfg_r.escape_byte   <= ESCAPE_RST;
      cfg_r.escape_offset <= OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/elfd_parse.sv
// Frame parser: per-byte state update and the registered result stage.
// Depends on elfd_pkg.
module elfd_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  elfd_pkg::cfg_t              cfg_i,
  input  logic                        byte_valid,
  input  logic [elfd_pkg::BYTE_W-1:0] byte_i,
  output logic                        byte_take,
  output logic                        res_valid,
  input  logic                        res_ready,
  output elfd_pkg::result_t           res_o
);
  import elfd_pkg::*;

  logic                escape_pending_r, escape_pending_nxt;
  logic [TAKEN_W-1:0]  bytes_taken_r, bytes_taken_nxt;
  logic [LEN_W-1:0]    frame_length_r, frame_length_nxt;
  logic [CNT_W-1:0]    abort_count_r, abort_count_nxt;
  logic                res_valid_r, res_valid_nxt;
  result_t             res_r, res_nxt;

  logic                emit;
  logic [BYTE_W-1:0]   ub;
  logic [LEN_W-1:0]    len_hi;
  logic [TAKEN_W-1:0]  idx_full;
  logic                is_last;

  // Consume a byte whenever the result register is free or draining.
  assign byte_take = byte_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res_o     = res_r;

  always_comb begin
    escape_pending_nxt = escape_pending_r;
    bytes_taken_nxt    = bytes_taken_r;
    frame_length_nxt   = frame_length_r;
    abort_count_nxt    = abort_count_r;
    emit               = 1'b0;
    res_nxt            = res_r;
    ub       = escape_pending_r ? (byte_i - cfg_i.escape_offset) : byte_i;
    len_hi   = {ub, frame_length_r[BYTE_W-1:0]};
    idx_full = bytes_taken_r - TAKEN_W'(2);
    is_last  = (bytes_taken_r - TAKEN_W'(1)) == {1'b0, frame_length_r};

    if (byte_i == cfg_i.start_byte) begin
      if (bytes_taken_r != '0) begin
        if (abort_count_r != '1) begin
          abort_count_nxt = abort_count_r + CNT_W'(1);
        end
        emit                 = 1'b1;
        res_nxt.kind         = KIND_ABORT;
        res_nxt.data         = '0;
        res_nxt.index        = '0;
        res_nxt.last         = 1'b0;
        res_nxt.frame_length = frame_length_r;
        res_nxt.error_count  = abort_count_nxt;
      end
      bytes_taken_nxt    = '0;
      escape_pending_nxt = 1'b0;
      frame_length_nxt   = '0;
    end else if (byte_i == cfg_i.escape_byte) begin
      escape_pending_nxt = 1'b1;
    end else begin
      escape_pending_nxt = 1'b0;
      if (bytes_taken_r == TAKEN_W'(0)) begin
        frame_length_nxt = {{(LEN_W-BYTE_W){1'b0}}, ub};
        bytes_taken_nxt  = TAKEN_W'(1);
      end else if (bytes_taken_r == TAKEN_W'(1)) begin
        frame_length_nxt = len_hi;
        if (len_hi == '0) begin
          emit                 = 1'b1;
          res_nxt.kind         = KIND_EMPTY;
          res_nxt.data         = '0;
          res_nxt.index        = '0;
          res_nxt.last         = 1'b1;
          res_nxt.frame_length = len_hi;
          res_nxt.error_count  = abort_count_r;
          bytes_taken_nxt      = '0;
        end else begin
          bytes_taken_nxt = TAKEN_W'(2);
        end
      end else begin
        emit                 = 1'b1;
        res_nxt.kind         = KIND_PAYLOAD;
        res_nxt.data         = ub;
        res_nxt.index        = idx_full[LEN_W-1:0];
        res_nxt.last         = is_last;
        res_nxt.frame_length = frame_length_r;
        res_nxt.error_count  = abort_count_r;
        bytes_taken_nxt      = is_last ? '0 : (bytes_taken_r + TAKEN_W'(1));
      end
    end

    if (!byte_take) begin
      escape_pending_nxt = escape_pending_r;
      bytes_taken_nxt    = bytes_taken_r;
      frame_length_nxt   = frame_length_r;
      abort_count_nxt    = abort_count_r;
      res_nxt            = res_r;
    end

    if (byte_take && emit) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_pending_r <= 1'b0;
      bytes_taken_r    <= '0;
      frame_length_r   <= '0;
      abort_count_r    <= '0;
      res_valid_r      <= 1'b0;
    end else begin
      escape_pending_r <= escape_pending_nxt;
      bytes_taken_r    <= bytes_taken_nxt;
      frame_length_r   <= frame_length_nxt;
      abort_count_r    <= abort_count_nxt;
      res_valid_r      <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

FILE: hdl/escaped_length_frame_deframer.sv
// Top level of the escaped length-prefixed frame deframer.
// Depends on elfd_pkg, elfd_cfg and elfd_parse.
//
// Usage:
//   in_*  : one raw line byte per request (valid/ready). A start byte opens a
//           frame, an escape byte offsets the byte after it, then two length
//           bytes (low first) precede the payload bytes.
//   out_* : zero or one result per input byte (valid/ready): a payload byte
//           with its index and last mark, an empty-frame event, or an abort
//           event when a start byte cuts a partly received frame.
//   cfg_* : register writes (start byte, escape byte, escape offset); the
//           port is always ready. Write only while no request is in flight.
// Path: an accepted request waits in the input register until the parser takes it,
//   then its result is held in the result register until taken.
// Throughput: one byte per cycle while out_ready stays high; the combinational
//   parse between the input register and the result register allows this rate.
// Reset (rst_n low, synchronous): registers return to 126/125/32, parse
//   state and the abort count clear, both stages empty.
// Receiver stall: a pending result holds in the result register; one more
//   request waits in the input register, then in_ready drops.
module escaped_length_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [elfd_pkg::BYTE_W-1:0]    in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [elfd_pkg::BYTE_W-1:0]    out_data,
  output logic [elfd_pkg::LEN_W-1:0]     out_index,
  output logic                           out_last,
  output logic [elfd_pkg::LEN_W-1:0]     out_frame_length,
  output logic [elfd_pkg::CNT_W-1:0]     out_error_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [elfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [elfd_pkg::BYTE_W-1:0]    cfg_data
);
  import elfd_pkg::*;

  cfg_t              cfg;
  result_t           res;
  logic              byte_take;
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;

  elfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Input register: accept a new byte when empty or being consumed this cycle.
  assign in_ready = !in_valid_r || byte_take;

  always_comb begin
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (byte_take) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Hold the byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  elfd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .byte_valid (in_valid_r),
    .byte_i     (in_byte_r),
    .byte_take  (byte_take),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_o      (res)
  );

  assign out_kind         = res.kind;
  assign out_data         = res.data;
  assign out_index        = res.index;
  assign out_last         = res.last;
  assign out_frame_length = res.frame_length;
  assign out_error_count  = res.error_count;

endmodule

FILE: tb/tb_escaped_length_frame_deframer.sv
// Self-checking bench for escaped_length_frame_deframer: directed table and random
// frames under several register settings, checked against a local deframer model.
// Depends on elfd_pkg and the escaped_length_frame_deframer RTL.
module tb_escaped_length_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import elfd_pkg::*;

  // Generous ceiling: it leaves a wide margin over the clean run even under the
  // heaviest idling.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORTS = 200;

  // One line byte waiting to go out. Rows of the directed table may carry a result
  // typed in by hand (fixed); everything else is checked against the model below.
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              fixed;
    logic              has;
    kind_t             kind;
    logic              last;
    logic [LEN_W-1:0]  flen;
    logic [CNT_W-1:0]  errs;
  } line_req_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [BYTE_W-1:0]    out_data;
  logic [LEN_W-1:0]     out_index;
  logic                 out_last;
  logic [LEN_W-1:0]     out_frame_length;
  logic [CNT_W-1:0]     out_error_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data  = '0;

  escaped_length_frame_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data         (out_data),
    .out_index        (out_index),
    .out_last         (out_last),
    .out_frame_length (out_frame_length),
    .out_error_count  (out_error_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deframer model: register copies and parse state, all at reset values.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  reg_start  = START_RST;
  logic [BYTE_W-1:0]  reg_escape = ESCAPE_RST;
  logic [BYTE_W-1:0]  reg_offset = OFFSET_RST;
  logic               esc_armed  = 1'b0;
  logic [TAKEN_W-1:0] taken      = '0;
  logic [LEN_W-1:0]   declared   = '0;
  logic [CNT_W-1:0]   aborts     = '0;

  // Advance the model by one line byte; got says whether a result comes out.
  task automatic deframe_byte(input logic [BYTE_W-1:0] raw, output logic got,
                              output result_t res);
    logic [BYTE_W-1:0]  b;
    logic [TAKEN_W-1:0] pos;
    b   = raw;
    got = 1'b0;
    res = '0;
    if (b == reg_start) begin
      // Start wins over escape; cut a partly received frame with an abort.
      if (taken != '0) begin
        if (aborts != '1) aborts = aborts + 1'b1;
        got = 1'b1;
        res.kind         = KIND_ABORT;
        res.frame_length = declared;
        res.error_count  = aborts;
      end
      taken     = '0;
      esc_armed = 1'b0;
      declared  = '0;
    end else if (b == reg_escape) begin
      esc_armed = 1'b1;
    end else begin
      if (esc_armed) begin
        b         = b - reg_offset;
        esc_armed = 1'b0;
      end
      if (taken == 0) begin
        declared = {8'h00, b};
        taken    = 17'd1;
      end else if (taken == 1) begin
        declared[15:8] = b;
        if (declared == '0) begin
          got = 1'b1;
          res.kind        = KIND_EMPTY;
          res.last        = 1'b1;
          res.error_count = aborts;
          taken = '0;
        end else begin
          taken = 17'd2;
        end
      end else begin
        pos = taken - 17'd2;
        got = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.data         = b;
        res.index        = pos[15:0];
        res.last         = ((taken - 17'd1) == {1'b0, declared});
        res.frame_length = declared;
        res.error_count  = aborts;
        taken = res.last ? '0 : taken + 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side: line_bytes feeds the input channel one request at a time.
  // ---------------------------------------------------------------------------
  line_req_t line_bytes [$];
  result_t   due_results [$];
  line_req_t on_wire;
  logic      req_got;
  result_t   req_res;
  int        bytes_queued    = 0;
  int        bytes_accepted  = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct  = 0;
  int        mismatches      = 0;
  int        cycles          = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        // Predict first, then let the hand-typed row override it.
        deframe_byte(on_wire.b, req_got, req_res);
        if (on_wire.fixed) begin
          req_got = on_wire.has;
          req_res = '0;
          req_res.kind         = on_wire.kind;
          req_res.last         = on_wire.last;
          req_res.frame_length = on_wire.flen;
          req_res.error_count  = on_wire.errs;
        end
        if (req_got) due_results.push_back(req_res);
        bytes_accepted++;
      end
      // Only load a new request once the current one is gone; hold otherwise.
      if (!in_valid || in_ready) begin
        if (line_bytes.size() != 0 &&
            !(sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)) begin
          on_wire  = line_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= on_wire.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver side: compare every accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  result_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result kind %0d expected none, got one", $realtime, out_kind);
        end else begin
          want = due_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("data", 16'(want.data), 16'(out_data));
          check_field("index", want.index, out_index);
          check_field("last", 16'(want.last), 16'(out_last));
          check_field("frame_length", want.frame_length, out_frame_length);
          check_field("error_count", want.error_count, out_error_count);
        end
      end
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("escaped_length_frame_deframer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    line_req_t r;
    r   = '0;
    r.b = b;
    line_bytes.push_back(r);
    bytes_queued++;
  endtask

  // Stuff control bytes with escape + offset; escape a few plain bytes as well.
  // With start equal to escape there is no way to stuff, so send raw.
  task automatic queue_encoded(input logic [BYTE_W-1:0] v);
    logic control;
    control = (v == reg_start) || (v == reg_escape);
    if (reg_start != reg_escape && (control || $urandom_range(0, 15) == 0)) begin
      queue_byte(reg_escape);
      queue_byte(v + reg_offset);
    end else begin
      queue_byte(v);
    end
  endtask

  // One frame: optional start, two length bytes, payload. About one in ten is
  // cut short by a start byte at a random point to force an abort.
  task automatic queue_frame();
    int          len;
    int          cut;
    int          pick;
    int          i;
    logic [15:0] flen;
    pick = $urandom_range(0, 99);
    if (pick < 8)       len = 0;
    else if (pick < 90) len = $urandom_range(1, 6);
    else if (pick < 99) len = $urandom_range(7, 40);
    else                len = $urandom_range(256, 260);
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 1) : -1;
    flen = len[15:0];
    if ($urandom_range(0, 3) != 0) queue_byte(reg_start);
    queue_encoded(flen[7:0]);
    if (cut == 0) begin
      queue_byte(reg_start);
      return;
    end
    queue_encoded(flen[15:8]);
    for (i = 0; i < len; i++) begin
      if (cut == i + 1) begin
        queue_byte(reg_start);
        return;
      end
      queue_encoded(8'($urandom_range(0, 255)));
    end
  endtask

  // Hold until every queued request is taken and every result has come back.
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START:  reg_start  = val;
      CFG_ESCAPE: reg_escape = val;
      CFG_OFFSET: reg_offset = val;
      default: ;
    endcase
  endtask

  // Mostly well-formed frames with random content, plus some line noise. The
  // segment drains at its end, so the sender sits idle until all results are in.
  task automatic run_segment(input int idle_pct, input int stall_pct, input int n_items);
    int goal;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    goal = bytes_queued + n_items;
    while (bytes_queued < goal) begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
      else
        queue_frame();
    end
    wait_drained();
  endtask

  // New register setting, then one pass through every idling pattern.
  task automatic run_phase(input logic [7:0] s, input logic [7:0] e, input logic [7:0] o);
    wait_drained();
    // A byte that yields no result may still sit in the pipe; let it clear.
    repeat (4) @(posedge clk);
    write_reg(CFG_START, s);
    write_reg(CFG_ESCAPE, e);
    write_reg(CFG_OFFSET, o);
    run_segment(0, 0, 26);
    run_segment(67, 0, 26);
    run_segment(0, 67, 26);
    run_segment(12, 12, 26);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, reset register values (start 7E, escape 7D, offset 20).
  // Fields: byte, fixed, has result, kind, last, frame length, error count.
  // ---------------------------------------------------------------------------
  line_req_t directed_rows [26];

  initial begin
    directed_rows = '{
      // length bytes right after reset, no start: zero length gives an empty frame
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h00, 1'b1, 1'b1, KIND_EMPTY,   1'b1, 16'h0000, 16'h0000},
      // length 3: payload FF, escape twice (stays pending) then 5E -> 3E, then 00
      '{8'h03, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h7D, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h7D, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h5E, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      // start with an escape pending and no frame open: silent
      '{8'h7D, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h7E, 1'b1, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      // abort inside the payload
      '{8'h05, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h11, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h7E, 1'b1, 1'b1, KIND_ABORT,   1'b0, 16'h0005, 16'h0001},
      // abort after one length byte reports the low byte only
      '{8'h33, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h7E, 1'b1, 1'b1, KIND_ABORT,   1'b0, 16'h0033, 16'h0002},
      // largest declared length, then aborted
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h7E, 1'b1, 1'b1, KIND_ABORT,   1'b0, 16'hFFFF, 16'h0003},
      // escaped length byte (21 -> 01), one payload byte, last
      '{8'h7D, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h21, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      // new length right after a completed frame, without a start byte
      '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'h0000, 16'h0000},
      '{8'h00, 1'b1, 1'b1, KIND_EMPTY,   1'b1, 16'h0000, 16'h0003}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      line_bytes.push_back(directed_rows[i]);
      bytes_queued++;
    end
    wait_drained();

    // Register extremes, start equal to escape, a random setting, back to reset values.
    run_phase(8'h00, 8'hFF, 8'hFF);
    run_phase(8'hFF, 8'h00, 8'h00);
    run_phase(8'h55, 8'h55, 8'h80);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    run_phase(START_RST, ESCAPE_RST, OFFSET_RST);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("escaped_length_frame_deframer: match");
    else
      $display("escaped_length_frame_deframer: mismatch");
    $finish;
  end

endmodule

FILE: files.f
hdl/elfd_pkg.sv
hdl/elfd_cfg.sv
hdl/elfd_parse.sv
hdl/escaped_length_frame_deframer.sv
tb/tb_escaped_length_frame_deframer.sv
